// ===== design/masked_template_diff_match_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the masked template difference match unit
// Concurrent property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MASKED_TEMPLATE_DIFF_MATCH_UNIT_ASSERT_SVH
`define MASKED_TEMPLATE_DIFF_MATCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTDM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mtdm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTDM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mtdm assertion failed");

`endif

// ===== design/mtdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mtdm_pkg
// Widths, constants and shared types of the masked template difference match.
// ----------------------------------------------------------------------------
package mtdm_pkg;

    localparam int PIX_W      = 8;
    localparam int ID_W       = 8;
    localparam int CNT_W      = 17;
    localparam int CFG_IDX_W  = 8;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - (2 * ID_W + 2 * CNT_W);

    localparam int MAX_PIXELS = 65536;
    localparam int CNT_MAX    = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT =
        (MAX_PIXELS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_PIXELS);
    localparam logic [CNT_W-1:0] CNT_ALL_ONES = '1;

    // Gray conversion: (B*1868 + G*9617 + R*4899 + 8192) >> 14
    localparam int GRAY_SHIFT = 14;
    localparam int GRAY_SUM_W = PIX_W + GRAY_SHIFT;
    localparam logic [GRAY_SHIFT-1:0] COEF_B = GRAY_SHIFT'(1868);
    localparam logic [GRAY_SHIFT-1:0] COEF_G = GRAY_SHIFT'(9617);
    localparam logic [GRAY_SHIFT-1:0] COEF_R = GRAY_SHIFT'(4899);
    localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = GRAY_SUM_W'(8192);

    localparam logic [PIX_W-1:0] THR_RESET = PIX_W'(63);

    localparam logic [CFG_IDX_W-1:0] REG_MASK_THR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THR = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PIX_W-1:0] tpl_r;
        logic [PIX_W-1:0] tpl_g;
        logic [PIX_W-1:0] tpl_b;
        logic [PIX_W-1:0] img_r;
        logic [PIX_W-1:0] img_g;
        logic [PIX_W-1:0] img_b;
    } pix_pair_t;

    typedef struct packed {
        logic [ID_W-1:0] template_id;
        logic            last_pixel;
        logic            last_template;
    } pix_tag_t;

    typedef struct packed {
        logic [CNT_W-1:0] best_count;
        logic [ID_W-1:0]  best_template;
        logic [CNT_W-1:0] diff_count;
        logic [ID_W-1:0]  done_template;
        logic             final_res;
    } match_res_t;

endpackage

// ===== design/mtdm_pixel_diff.sv =====
// ----------------------------------------------------------------------------
// mtdm_pixel_diff
// Masks the image pixel, takes the channel differences to the template,
// converts them to gray and flags a mismatched pixel.
// ----------------------------------------------------------------------------
module mtdm_pixel_diff (
    input  mtdm_pkg::pix_pair_t         pix,
    input  logic [mtdm_pkg::PIX_W-1:0]  mask_thr,
    input  logic [mtdm_pkg::PIX_W-1:0]  diff_thr,
    output logic                        mismatch
);
    import mtdm_pkg::*;

    logic [PIX_W-1:0]      d_b;
    logic [PIX_W-1:0]      d_g;
    logic [PIX_W-1:0]      d_r;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [PIX_W-1:0]      gray;

    function automatic logic [PIX_W-1:0] chan_diff(
        input logic [PIX_W-1:0] img,
        input logic [PIX_W-1:0] tpl,
        input logic [PIX_W-1:0] thr
    );
        logic [PIX_W-1:0] kept;
        kept = (tpl > thr) ? img : '0;
        return (tpl > kept) ? (tpl - kept) : (kept - tpl);
    endfunction

    always_comb begin
        d_b = chan_diff(pix.img_b, pix.tpl_b, mask_thr);
        d_g = chan_diff(pix.img_g, pix.tpl_g, mask_thr);
        d_r = chan_diff(pix.img_r, pix.tpl_r, mask_thr);
        // Operands are widened first so that no product loses its upper bits.
        gray_sum = GRAY_SUM_W'(d_b) * GRAY_SUM_W'(COEF_B)
                 + GRAY_SUM_W'(d_g) * GRAY_SUM_W'(COEF_G)
                 + GRAY_SUM_W'(d_r) * GRAY_SUM_W'(COEF_R) + GRAY_ROUND;
        gray     = gray_sum[GRAY_SUM_W-1:GRAY_SHIFT];
        mismatch = gray > diff_thr;
    end

endmodule

// ===== design/mtdm_accum.sv =====
// ----------------------------------------------------------------------------
// mtdm_accum
// Mismatch counter, best-template tracker and the result register.
// ----------------------------------------------------------------------------
module mtdm_accum (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  mtdm_pkg::pix_tag_t    in_tag,
    input  logic                  mismatch,
    output logic                  in_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    output mtdm_pkg::match_res_t  res
);
    import mtdm_pkg::*;

    logic [CNT_W-1:0] running_count_reg, running_count_next;
    logic [CNT_W-1:0] best_count_reg, best_count_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;
    logic             no_best_yet_reg, no_best_yet_next;
    logic             res_valid_reg, res_valid_next;
    match_res_t       res_reg, res_next;

    logic             out_free;
    logic             take;
    logic             close;
    logic             new_best;
    logic [CNT_W-1:0] cnt;

    always_comb begin
        out_free = !res_valid_reg || res_ready;
        // Pixels that produce no result never wait on the output side.
        in_ready = !in_tag.last_pixel || out_free;
        take     = in_valid && in_ready;
        close    = take && in_tag.last_pixel;

        cnt = running_count_reg;
        if (mismatch && (running_count_reg < CNT_LIMIT)) begin
            cnt = running_count_reg + CNT_W'(1);
        end
        new_best = no_best_yet_reg || (cnt < best_count_reg);

        running_count_next = running_count_reg;
        best_count_next    = best_count_reg;
        best_id_next       = best_id_reg;
        no_best_yet_next   = no_best_yet_reg;
        res_next           = res_reg;
        res_valid_next     = res_valid_reg && !res_ready;

        if (take) begin
            running_count_next = cnt;
        end
        if (close) begin
            running_count_next     = '0;
            res_valid_next         = 1'b1;
            res_next.done_template = in_tag.template_id;
            res_next.diff_count    = cnt;
            res_next.best_template = new_best ? in_tag.template_id : best_id_reg;
            res_next.best_count    = new_best ? cnt : best_count_reg;
            res_next.final_res     = in_tag.last_template;
            if (in_tag.last_template) begin
                best_count_next  = CNT_ALL_ONES;
                best_id_next     = '0;
                no_best_yet_next = 1'b1;
            end else if (new_best) begin
                best_count_next  = cnt;
                best_id_next     = in_tag.template_id;
                no_best_yet_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_count_reg <= '0;
            best_count_reg    <= CNT_ALL_ONES;
            best_id_reg       <= '0;
            no_best_yet_reg   <= 1'b1;
            res_valid_reg     <= 1'b0;
        end else begin
            running_count_reg <= running_count_next;
            best_count_reg    <= best_count_next;
            best_id_reg       <= best_id_next;
            no_best_yet_reg   <= no_best_yet_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/masked_template_diff_match_unit.sv =====
// A pixel pair accepted from the input stream sits in the input register; once the accumulator
// takes it, its result is loaded into the result register.
// Throughput: one pixel pair per cycle; only a stalled result blocks a closing pixel.
// Reset (aresetn low, synchronous): both thresholds return to 63, the running count to
// zero, the best count to all ones and the best template to zero; no result is pending.
// ----------------------------------------------------------------------------
// masked_template_diff_match_unit
// Streams image/template pixel pairs and reports per-template mismatch counts
// together with the best (lowest count) template of the current set.
// ----------------------------------------------------------------------------
module masked_template_diff_match_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // img_b, img_g, img_r, tpl_b, tpl_g, tpl_r, template_id (8 bits each)
    input  logic [mtdm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    // last_template
    input  logic                                s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // done_template (8), diff_count (17), best_template (8), best_count (17), zero pad (6)
    output logic [mtdm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtdm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtdm_pkg::PIX_W-1:0]          cfg_data
);
    import mtdm_pkg::*;

    logic [PIX_W-1:0] mask_thr_reg, mask_thr_next;
    logic [PIX_W-1:0] diff_thr_reg, diff_thr_next;

    logic             in_valid_reg, in_valid_next;
    pix_pair_t        pix_reg, pix_next;
    pix_tag_t         tag_reg, tag_next;

    logic             s_accept;
    logic             mismatch;
    logic             acc_ready;
    match_res_t       res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || acc_ready;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        mask_thr_next = mask_thr_reg;
        diff_thr_next = diff_thr_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_MASK_THR: mask_thr_next = cfg_data;
                REG_DIFF_THR: diff_thr_next = cfg_data;
                default:      ;
            endcase
        end

        in_valid_next = s_accept || (in_valid_reg && !acc_ready);
        pix_next      = pix_reg;
        tag_next      = tag_reg;
        if (s_accept) begin
            pix_next.img_b         = s_tdata[7:0];
            pix_next.img_g         = s_tdata[15:8];
            pix_next.img_r         = s_tdata[23:16];
            pix_next.tpl_b         = s_tdata[31:24];
            pix_next.tpl_g         = s_tdata[39:32];
            pix_next.tpl_r         = s_tdata[47:40];
            tag_next.template_id   = s_tdata[55:48];
            tag_next.last_pixel    = s_tlast;
            tag_next.last_template = s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_thr_reg <= THR_RESET;
            diff_thr_reg <= THR_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            mask_thr_reg <= mask_thr_next;
            diff_thr_reg <= diff_thr_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
        tag_reg <= tag_next;
    end

    mtdm_pixel_diff u_pixel_diff (
        .pix      (pix_reg),
        .mask_thr (mask_thr_reg),
        .diff_thr (diff_thr_reg),
        .mismatch (mismatch)
    );

    mtdm_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_tag    (tag_reg),
        .mismatch  (mismatch),
        .in_ready  (acc_ready),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {M_PAD_W'(0), res.best_count, res.best_template,
                      res.diff_count, res.done_template};
    assign m_tlast = res.final_res;

endmodule

// ===== design/mtdm_checker.sv =====
// ----------------------------------------------------------------------------
// mtdm_checker
// Port-level checks on the result stream of the match unit.
// ----------------------------------------------------------------------------
`include "masked_template_diff_match_unit_assert.svh"

module mtdm_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mtdm_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                m_tlast
);
    import mtdm_pkg::*;

    logic             m_stall;
    logic [CNT_W-1:0] diff_cnt;
    logic [CNT_W-1:0] best_cnt;

    assign m_stall  = m_tvalid && !m_tready;
    assign diff_cnt = m_tdata[24:8];
    assign best_cnt = m_tdata[49:33];

    // A waiting result transaction is neither dropped nor altered.
    `MTDM_ASSERT_NEXT(a_res_held, aclk, aresetn, m_stall, m_tvalid)
    `MTDM_ASSERT_NEXT(a_res_stable, aclk, aresetn, m_stall,
                      $stable(m_tdata) && $stable(m_tlast))

    // The reported best can never be worse than the template just finished.
    `MTDM_ASSERT_NOW(a_best_le_count, aclk, aresetn, m_tvalid, best_cnt <= diff_cnt)

    // The count saturates at its limit.
    `MTDM_ASSERT_NOW(a_count_limit, aclk, aresetn, m_tvalid, diff_cnt <= CNT_LIMIT)

endmodule

bind masked_template_diff_match_unit mtdm_checker u_mtdm_checker (.*);

// ===== bench/masked_template_diff_match_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_template_diff_match_unit_tb
// Streams image/template pixel pairs through the match unit while both stream
// sides stall at random, and compares every result against a local
// per-template mismatch counter that tracks the best template of each set.
// ----------------------------------------------------------------------------
module masked_template_diff_match_unit_tb;

    import mtdm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_DIFF_THR + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;
    localparam int MAX_REPORTS = 200;

    typedef struct {
        pix_pair_t       px;
        logic [ID_W-1:0] tpl_id;
        logic            last_pix;
        logic            last_set;
    } pixel_txn_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PIX_W-1:0] cfg_data = '0;

    // Local copy of the block's configuration and counting state.
    logic [PIX_W-1:0] thr_mask;
    logic [PIX_W-1:0] thr_diff;
    logic [CNT_W-1:0] mismatch_run;
    logic [CNT_W-1:0] best_cnt;
    logic [ID_W-1:0]  best_id;
    logic             set_open;

    match_res_t pending_matches[$];
    int err_cnt = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;

    masked_template_diff_match_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    function automatic logic [PIX_W-1:0] masked_diff(logic [PIX_W-1:0] img,
                                                     logic [PIX_W-1:0] tpl);
        logic [PIX_W-1:0] kept;
        kept = (tpl > thr_mask) ? img : '0;
        return (tpl > kept) ? tpl - kept : kept - tpl;
    endfunction

    function automatic void clear_best_template();
        best_cnt = CNT_ALL_ONES;
        best_id  = '0;
        set_open = 1'b1;
    endfunction

    // Updates the mismatch counter for one pixel and queues the template result
    // when the pixel closes a template.
    function automatic void predict_match(pixel_txn_t it);
        int gray;
        match_res_t res;
        gray = (int'(masked_diff(it.px.img_b, it.px.tpl_b)) * int'(COEF_B)
              + int'(masked_diff(it.px.img_g, it.px.tpl_g)) * int'(COEF_G)
              + int'(masked_diff(it.px.img_r, it.px.tpl_r)) * int'(COEF_R)
              + int'(GRAY_ROUND)) >> GRAY_SHIFT;
        if (mismatch_run > CNT_LIMIT) mismatch_run = CNT_LIMIT;
        if (gray > int'(thr_diff) && mismatch_run < CNT_LIMIT) mismatch_run++;
        if (!it.last_pix) return;
        if (set_open || mismatch_run < best_cnt) begin
            best_cnt = mismatch_run;
            best_id  = it.tpl_id;
            set_open = 1'b0;
        end
        res.done_template = it.tpl_id;
        res.diff_count    = mismatch_run;
        res.best_template = best_id;
        res.best_count    = best_cnt;
        res.final_res     = it.last_set;
        pending_matches = {pending_matches, res};
        mismatch_run = '0;
        if (it.last_set) clear_best_template();
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] exp_val,
                                        logic [CNT_W-1:0] act_val);
        if (exp_val !== act_val) begin
            if (err_cnt < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        match_res_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matches.size() == 0) begin
                if (err_cnt < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual tdata %0h last %0b",
                             $time, m_tdata, m_tlast);
                err_cnt++;
            end else begin
                exp_res = pending_matches.pop_front();
                check_field("done_template", CNT_W'(exp_res.done_template),
                            CNT_W'(m_tdata[7:0]));
                check_field("diff_count", exp_res.diff_count, m_tdata[24:8]);
                check_field("best_template", CNT_W'(exp_res.best_template),
                            CNT_W'(m_tdata[32:25]));
                check_field("best_count", exp_res.best_count, m_tdata[49:33]);
                check_field("final_res", CNT_W'(exp_res.final_res), CNT_W'(m_tlast));
            end
        end
    end

    // One pixel pair; returns at the edge where the transaction is accepted.
    task automatic push_pixel(pixel_txn_t it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.tpl_id, it.px};
        s_tlast  <= it.last_pix;
        s_tuser  <= it.last_set;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_match(it);
    endtask

    // Lets the block run dry so that a register write cannot overtake a pixel.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_MASK_THR: thr_mask = val;
            REG_DIFF_THR: thr_diff = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Channels are given as 24-bit words with blue in the low byte.
    function automatic pixel_txn_t mk_pixel(logic [23:0] img, logic [23:0] tpl,
                                            logic [ID_W-1:0] id, logic lp, logic lt);
        pixel_txn_t it;
        it.px.img_b = img[7:0];
        it.px.img_g = img[15:8];
        it.px.img_r = img[23:16];
        it.px.tpl_b = tpl[7:0];
        it.px.tpl_g = tpl[15:8];
        it.px.tpl_r = tpl[23:16];
        it.tpl_id   = id;
        it.last_pix = lp;
        it.last_set = lt;
        return it;
    endfunction

    // Reset thresholds: masking edge, gray edge, ties, mixed ids and set ends.
    task automatic test_reset_thresholds();
        src_idle_pct  = 37;
        sink_idle_pct = 50;
        push_pixel(mk_pixel(24'h000000, 24'h000000, 8'd5, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'hFFFFFF, 24'hFFFFFF, 8'd5, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 8'd5, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'h000000, 24'h404040, 8'd5, 1'b0, 1'b1));
        push_pixel(mk_pixel(24'h000000, 24'h3F3F3F, 8'd5, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'h00FF00, 24'hFF00FF, 8'd5, 1'b1, 1'b0));
        // Same count as the first template, so the first one stays best.
        push_pixel(mk_pixel(24'h123456, 24'hFFFFFF, 8'd200, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'h000000, 24'h808080, 8'd9, 1'b1, 1'b0));
        push_pixel(mk_pixel(24'h414141, 24'h414141, 8'd0, 1'b1, 1'b1));
        // A new set starts; its first template is best whatever its count.
        push_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 8'd255, 1'b1, 1'b1));
        drain_stream();
    endtask

    task automatic test_threshold_extremes();
        src_idle_pct  = 50;
        sink_idle_pct = 37;
        cfg_write(REG_MASK_THR, 8'd0);
        cfg_write(REG_DIFF_THR, 8'd0);
        push_pixel(mk_pixel(24'h000000, 24'h010101, 8'd1, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'h000000, 24'h000000, 8'd1, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'hFF0000, 24'h00FF01, 8'd1, 1'b1, 1'b0));
        push_pixel(mk_pixel(24'hAA55AA, 24'hAA55AA, 8'd2, 1'b1, 1'b1));
        drain_stream();
        cfg_write(REG_MASK_THR, 8'd255);
        cfg_write(REG_DIFF_THR, 8'd255);
        push_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 8'd3, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'hFFFFFF, 24'hFFFFFF, 8'd3, 1'b1, 1'b0));
        drain_stream();
        // Writes to indexes past the register list must not land anywhere.
        cfg_write(REG_UNUSED_LO, 8'd0);
        cfg_write(REG_UNUSED_HI, 8'd0);
        cfg_write(REG_DIFF_THR, 8'd254);
        push_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 8'd4, 1'b0, 1'b0));
        push_pixel(mk_pixel(24'hFFFFFF, 24'hFEFEFE, 8'd4, 1'b1, 1'b1));
        drain_stream();
    endtask

    function automatic logic [PIX_W-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return THR_RESET;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] random_chan(logic [PIX_W-1:0] img);
        int v;
        case ($urandom_range(0, 2))
            0: return PIX_W'($urandom_range(0, 255));
            1: begin
                // Hover around the mask threshold.
                v = int'(thr_mask) + $urandom_range(0, 4) - 2;
                return PIX_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
            end
            default: return img ^ PIX_W'($urandom_range(0, 255) & $urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed template sets with random content, with a share of broken
    // framing mixed in; thresholds change before every group of four sets.
    task automatic test_random_sets(int src_pct, int sink_pct, int n_items);
        int sent;
        int n_tpl;
        int n_pix;
        int t;
        int p;
        pixel_txn_t it;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_items) begin
            drain_stream();
            cfg_write(REG_MASK_THR, pick_threshold());
            cfg_write(REG_DIFF_THR, pick_threshold());
            repeat (4) begin
                n_tpl = $urandom_range(1, 5);
                for (t = 0; t < n_tpl; t++) begin
                    n_pix = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                        : $urandom_range(1, 6);
                    it.tpl_id = ID_W'($urandom_range(0, 255));
                    for (p = 0; p < n_pix; p++) begin
                        it.px.img_b = PIX_W'($urandom_range(0, 255));
                        it.px.img_g = PIX_W'($urandom_range(0, 255));
                        it.px.img_r = PIX_W'($urandom_range(0, 255));
                        it.px.tpl_b = random_chan(it.px.img_b);
                        it.px.tpl_g = random_chan(it.px.img_g);
                        it.px.tpl_r = random_chan(it.px.img_r);
                        it.last_pix = (p == n_pix - 1);
                        it.last_set = it.last_pix && (t == n_tpl - 1);
                        if ($urandom_range(0, 9) == 0) begin
                            it.last_pix = 1'($urandom_range(0, 1));
                            it.last_set = 1'($urandom_range(0, 1));
                        end
                        if ($urandom_range(0, 15) == 0)
                            it.tpl_id = ID_W'($urandom_range(0, 255));
                        push_pixel(it);
                        sent++;
                    end
                end
            end
        end
        drain_stream();
    endtask

    initial begin
        thr_mask     = THR_RESET;
        thr_diff     = THR_RESET;
        mismatch_run = '0;
        clear_best_template();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_thresholds();
        test_threshold_extremes();
        test_random_sets(37, 50, 280);
        test_random_sets(50, 37, 280);
        test_random_sets(0, 0, 280);

        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mtdm_pkg.sv
design/mtdm_pixel_diff.sv
design/mtdm_accum.sv
design/masked_template_diff_match_unit.sv
design/mtdm_checker.sv
bench/masked_template_diff_match_unit_tb.sv
